// ===== src/mdst_pkg.sv =====
// Shared constants and controller/datapath interface types for the message
// deframer with subscriber table. No dependencies.
`default_nettype none

package mdst_pkg;

    // Table and packet sizing
    localparam int MAX_SUBSCRIBERS  = 5;
    localparam int MAX_PACKET_BYTES = 1500;
    localparam int POS_W            = 11;
    localparam int HDR_LEN          = 8;

    // Header field offsets
    localparam int OFS_VERSION = 0;
    localparam int OFS_FLAGS   = 3;
    localparam int OFS_ID_HI   = 4;
    localparam int OFS_ID_LO   = 5;
    localparam int OFS_SIZE_HI = 6;
    localparam int OFS_SIZE_LO = 7;

    // Message codes
    localparam logic [7:0]  PROTO_VERSION = 8'd1;
    localparam logic [15:0] SYS_ID_LIMIT  = 16'h000F;
    localparam logic [15:0] ADD_SUB_ID    = 16'h0003;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;     // input transfer taken this cycle
        logic sel_pay;  // present the payload result on the output
    } mdst_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit_pay; // current input byte yields a payload result
        logic emit_sum; // current input byte yields a summary result
    } mdst_stat_t;

endpackage

`default_nettype wire

// ===== src/mdst_ctrl.sv =====
// Handshake controller: tracks which results are pending in the output
// registers. Depends on mdst_pkg.
`default_nettype none

module mdst_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    input  mdst_pkg::mdst_stat_t stat,
    output mdst_pkg::mdst_cmd_t  cmd
);
    import mdst_pkg::*;

    // Pending-result states
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_PAY   = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_BOTH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;
    logic       acc;

    // Input may enter when the output is empty or its only result leaves now
    assign m_tvalid = (state_reg != ST_EMPTY);
    assign s_tready = (state_reg == ST_EMPTY) ||
                      (m_tready && ((state_reg == ST_PAY) || (state_reg == ST_SUM)));
    assign take     = m_tvalid && m_tready;
    assign acc      = s_tvalid && s_tready;

    assign cmd.load    = acc;
    assign cmd.sel_pay = (state_reg == ST_PAY) || (state_reg == ST_BOTH);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (acc)
        begin
            state_next = {stat.emit_sum, stat.emit_pay};
        end
        else if (take)
        begin
            case (state_reg)
                ST_BOTH:  state_next = ST_SUM;
                ST_PAY:   state_next = ST_EMPTY;
                ST_SUM:   state_next = ST_EMPTY;
                default:  state_next = ST_EMPTY;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mdst_datapath.sv =====
// Datapath: header capture, payload gating, subscriber table and result
// registers. Depends on mdst_pkg.
`default_nettype none

module mdst_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  [7:0]           rx_byte,
    input  wire  [31:0]          sender_ip,
    input  wire                  end_of_packet,
    input  mdst_pkg::mdst_cmd_t  cmd,
    output mdst_pkg::mdst_stat_t stat,
    output logic                 kind,
    output logic [15:0]          msg_id,
    output logic [15:0]          payload_size,
    output logic [7:0]           msg_flags,
    output logic [7:0]           payload_byte,
    output logic                 subscriber_added,
    output logic                 table_full,
    output logic                 last
);
    import mdst_pkg::*;

    // Packet state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       ver_reg, ver_next;
    logic [7:0]       flg_reg, flg_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      size_reg, size_next;

    // Subscriber table
    logic [31:0]                addr_reg [MAX_SUBSCRIBERS];
    logic [MAX_SUBSCRIBERS-1:0] vld_reg;
    logic [MAX_SUBSCRIBERS-1:0] match;
    logic [MAX_SUBSCRIBERS-1:0] wr_sel;
    logic                       present;
    logic                       tbl_full;

    // Result registers
    logic [15:0] pay_id_reg, pay_size_reg;
    logic [7:0]  pay_flg_reg, pay_data_reg;
    logic [15:0] sum_id_reg, sum_size_reg;
    logic [7:0]  sum_flg_reg;
    logic        sum_added_reg, sum_full_reg;

    logic        in_range;
    logic [15:0] pay_ofs;
    logic        emit_pay;
    logic        hdr_ok;
    logic        is_sys;
    logic        add_req;
    logic        do_add;

    // Header capture and byte counting
    assign in_range = (pos_reg < POS_W'(MAX_PACKET_BYTES));
    assign pay_ofs  = 16'({5'd0, pos_reg} - 16'(HDR_LEN));

    always_comb
    begin
        ver_next  = ver_reg;
        flg_next  = flg_reg;
        id_next   = id_reg;
        size_next = size_reg;
        pos_next  = pos_reg;
        if (in_range)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (pos_reg)
                POS_W'(OFS_VERSION): ver_next  = rx_byte;
                POS_W'(OFS_FLAGS):   flg_next  = rx_byte;
                POS_W'(OFS_ID_HI):   id_next   = {rx_byte, 8'd0};
                POS_W'(OFS_ID_LO):   id_next   = {id_reg[15:8], rx_byte};
                POS_W'(OFS_SIZE_HI): size_next = {rx_byte, 8'd0};
                POS_W'(OFS_SIZE_LO): size_next = {size_reg[15:8], rx_byte};
                default:             ;
            endcase
        end
    end

    // Payload byte gating
    assign emit_pay = in_range && (pos_reg >= POS_W'(HDR_LEN)) &&
                      (ver_reg == PROTO_VERSION) && (id_reg >= SYS_ID_LIMIT) &&
                      (pay_ofs < size_reg);

    assign stat.emit_pay = emit_pay;
    assign stat.emit_sum = end_of_packet;

    // Summary decode
    assign hdr_ok  = (pos_next >= POS_W'(HDR_LEN)) && (ver_next == PROTO_VERSION);
    assign is_sys  = (id_next < SYS_ID_LIMIT);
    assign add_req = hdr_ok && is_sys && (id_next == ADD_SUB_ID);

    // Table lookup: valid entries form a prefix, so the first free slot is the write slot
    always_comb
    begin
        logic found;
        found  = 1'b0;
        wr_sel = '0;
        for (int i = 0; i < MAX_SUBSCRIBERS; i++)
        begin
            match[i] = vld_reg[i] && (addr_reg[i] == sender_ip);
            if (!found && !vld_reg[i])
            begin
                wr_sel[i] = 1'b1;
                found     = 1'b1;
            end
        end
    end

    assign present  = |match;
    assign tbl_full = &vld_reg;
    assign do_add   = cmd.load && end_of_packet && add_req && !present && !tbl_full;

    // Control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ver_reg  <= '0;
            flg_reg  <= '0;
            id_reg   <= '0;
            size_reg <= '0;
            vld_reg  <= '0;
        end
        else if (cmd.load)
        begin
            if (end_of_packet)
            begin
                pos_reg  <= '0;
                ver_reg  <= '0;
                flg_reg  <= '0;
                id_reg   <= '0;
                size_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                ver_reg  <= ver_next;
                flg_reg  <= flg_next;
                id_reg   <= id_next;
                size_reg <= size_next;
            end
            if (do_add)
            begin
                vld_reg <= vld_reg | wr_sel;
            end
        end
    end

    // Table addresses and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SUBSCRIBERS; i++)
        begin
            if (do_add && wr_sel[i])
            begin
                addr_reg[i] <= sender_ip;
            end
        end
        if (cmd.load)
        begin
            pay_id_reg    <= id_reg;
            pay_size_reg  <= size_reg;
            pay_flg_reg   <= flg_reg;
            pay_data_reg  <= rx_byte;
            sum_id_reg    <= (hdr_ok && !is_sys) ? id_next : 16'd0;
            sum_size_reg  <= (hdr_ok && !is_sys) ? size_next : 16'd0;
            sum_flg_reg   <= hdr_ok ? flg_next : 8'd0;
            sum_added_reg <= add_req && !present && !tbl_full;
            sum_full_reg  <= add_req && !present && tbl_full;
        end
    end

    // Output selection
    always_comb
    begin
        if (cmd.sel_pay)
        begin
            kind             = KIND_PAYLOAD;
            msg_id           = pay_id_reg;
            payload_size     = pay_size_reg;
            msg_flags        = pay_flg_reg;
            payload_byte     = pay_data_reg;
            subscriber_added = 1'b0;
            table_full       = 1'b0;
            last             = 1'b0;
        end
        else
        begin
            kind             = KIND_SUMMARY;
            msg_id           = sum_id_reg;
            payload_size     = sum_size_reg;
            msg_flags        = sum_flg_reg;
            payload_byte     = 8'd0;
            subscriber_added = sum_added_reg;
            table_full       = sum_full_reg;
            last             = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== src/message_deframer_with_subscriber_table_core.sv =====
// Top level of the message deframer with subscriber table.
// Depends on mdst_pkg, mdst_ctrl and mdst_datapath.
//
// Usage:
//   Slave stream carries one datagram byte per transfer with the sender
//   address; s_tlast marks the final byte. The master stream carries
//   results: payload bytes of user messages (m_tuser 0) and one summary
//   per datagram (m_tuser 1, m_tlast 1) with id, size, flags and the
//   subscriber-table outcome.
//   A result is registered and presented in the cycle after the input
//   transfer. Throughput: one byte per cycle while the receiver takes
//   every result. A final byte that also carries payload yields two
//   results; the input then waits while the payload result drains. The
//   output registers hold one input's results; s_tready is high when
//   they are empty or their single result leaves.
//   When the receiver stalls, results hold and input is refused.
//   Reset empties the subscriber table and clears the header state; the
//   table keeps its contents across datagrams until the next reset.
`default_nettype none

module message_deframer_with_subscriber_table_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [7:0] rx_byte, [39:8] sender_ip
    input  wire         s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [15:0] msg_id, [31:16] payload_size,
                                   // [39:32] msg_flags, [47:40] payload_byte,
                                   // [48] subscriber_added, [49] table_full,
                                   // [55:50] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);
    import mdst_pkg::*;

    mdst_cmd_t   cmd;
    mdst_stat_t  stat;
    logic [15:0] msg_id;
    logic [15:0] payload_size;
    logic [7:0]  msg_flags;
    logic [7:0]  payload_byte;
    logic        subscriber_added;
    logic        table_full;

    mdst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mdst_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (s_tdata[7:0]),
        .sender_ip        (s_tdata[39:8]),
        .end_of_packet    (s_tlast),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (m_tuser),
        .msg_id           (msg_id),
        .payload_size     (payload_size),
        .msg_flags        (msg_flags),
        .payload_byte     (payload_byte),
        .subscriber_added (subscriber_added),
        .table_full       (table_full),
        .last             (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {6'd0, table_full, subscriber_added, payload_byte,
                      msg_flags, payload_size, msg_id};

endmodule

`default_nettype wire

// ===== src/mdst_checker.sv =====
// Port-level checker for the message deframer top level, with its bind.
// Depends on message_deframer_with_subscriber_table_core.
`default_nettype none

module mdst_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Only the summary closes a datagram
    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("last mark does not match result kind");

    // Payload results carry no table outcome
    a_pay_no_table: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[49:48] == 2'b00))
        else $error("table flags set on payload result");

    // A zero id is always reported with a zero size
    a_zero_id_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:0] == 16'd0) |-> (m_tdata[31:16] == 16'd0))
        else $error("size reported with zero id");

endmodule

bind message_deframer_with_subscriber_table_core mdst_checker u_mdst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
